// ===== src/onewire_rom_key_check_unit_assert.svh =====
// Assertion macros for the ROM key check unit.
// OWKC_ASSERT checks a property on every rising clock edge outside reset.
// OWKC_ASSERT_IMP checks that an antecedent implies a consequent in the same cycle.
`ifndef ONEWIRE_ROM_KEY_CHECK_UNIT_ASSERT_SVH
`define ONEWIRE_ROM_KEY_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define OWKC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OWKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define OWKC_ASSERT(lbl, clk, rst_n, prop, msg)
`define OWKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/owkc_pkg.sv =====
package owkc_pkg;

	localparam int MAX_KEY_SLOTS = 5;
	localparam int SERIAL_W      = 48;
	localparam int SERIAL_BYTES  = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int SLOT_IDX_W    = 3;

	localparam logic [7:0] CRC_POLY   = 8'h8C;
	localparam logic [7:0] FAMILY_KEY = 8'h01;

	// byte positions inside a ROM frame
	localparam logic [2:0] BYTE_POS_FAMILY  = 3'd0;
	localparam logic [2:0] BYTE_POS_SERIAL0 = 3'd1;
	localparam logic [2:0] BYTE_POS_CRC     = 3'd7;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_KEY_SLOT_ZERO  = 3'd0;
	localparam reg_idx_t REG_KEY_SLOT_ONE   = 3'd1;
	localparam reg_idx_t REG_KEY_SLOT_TWO   = 3'd2;
	localparam reg_idx_t REG_KEY_SLOT_THREE = 3'd3;
	localparam reg_idx_t REG_KEY_SLOT_FOUR  = 3'd4;
	localparam reg_idx_t REG_SLOT_ENABLE    = 3'd5;

	localparam reg_idx_t KEY_SLOT_REG [MAX_KEY_SLOTS] = '{
		REG_KEY_SLOT_ZERO, REG_KEY_SLOT_ONE, REG_KEY_SLOT_TWO,
		REG_KEY_SLOT_THREE, REG_KEY_SLOT_FOUR
	};

	typedef struct packed {
		logic [7:0] rom_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [SERIAL_W-1:0]   serial_number;
		logic [7:0]            family_code;
		logic                  crc_ok;
		logic                  key_present;
		logic                  key_allowed;
		logic [SLOT_IDX_W-1:0] matched_slot;
	} out_item_t;

	// reflected CRC-8, one byte, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/onewire_rom_key_check_unit.sv =====
// ROM key check unit.
// Takes the eight bytes of a 1-Wire ROM read, one byte per input transaction
// (family code, six serial bytes, CRC). After the eighth byte it emits one
// result transaction with the serial number, the family code, the CRC verdict,
// key presence and the lowest enabled key slot whose serial matches.
// Channels: in_valid/in_stall/in_item and out_valid/out_stall/out_item; a
// transaction moves when valid is high and stall is low. frame_start marks
// byte 0 and restarts the byte count and CRC; without it, frames follow on.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high. Index 0..4 write key slots, 5 writes the enable mask, others are
// dropped. Write configuration only while the unit is idle.
// Each byte taken in is registered into stage 1 and processed there; a
// frame's last byte then loads its result into the output register.
// Throughput: one byte per cycle through the single CRC/compare stage, except while a last byte waits on a held output.
// When the receiver stalls a finished result, the unit keeps taking bytes that
// produce no result; only a frame's last byte waits behind the held output.
// Reset clears the CRC, byte count, captured family and serial, the key slots
// and the enable mask, and empties both pipeline registers.
`include "onewire_rom_key_check_unit_assert.svh"

module onewire_rom_key_check_unit #(
	parameter int NUM_KEY_SLOTS = owkc_pkg::MAX_KEY_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  owkc_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output owkc_pkg::out_item_t               out_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  owkc_pkg::reg_idx_t                cfg_index,
	input  logic [owkc_pkg::SERIAL_W-1:0]     cfg_data
);
	import owkc_pkg::*;

	// configuration registers
	logic [SERIAL_W-1:0]      key_slot_q [NUM_KEY_SLOTS];
	logic [NUM_KEY_SLOTS-1:0] slot_en_q;

	// frame state
	logic [7:0]          crc_q;
	logic [2:0]          byte_cnt_q;
	logic [7:0]          family_q;
	logic [SERIAL_W-1:0] serial_q;

	// stage 1: registered input byte
	logic     valid_s1;
	in_item_t item_s1;

	// output register
	logic      out_valid_q;
	out_item_t out_item_q;

	// stage 1 datapath
	logic [2:0]            pos_s1;
	logic [7:0]            crc_base_s1;
	logic [7:0]            crc_next_s1;
	logic                  last_s1;
	logic                  advance_s1;
	logic                  fire_s1;
	logic                  crc_ok_s1;
	logic                  present_s1;
	logic                  hit_s1;
	logic [SLOT_IDX_W-1:0] hit_slot_s1;
	out_item_t             result_s1;

	assign cfg_ready = 1'b1;

	// frame_start restarts count and CRC before the byte is folded in
	assign pos_s1      = item_s1.frame_start ? BYTE_POS_FAMILY : byte_cnt_q;
	assign crc_base_s1 = item_s1.frame_start ? 8'h00 : crc_q;
	assign crc_next_s1 = crc8_byte(crc_base_s1, item_s1.rom_byte);
	assign last_s1     = (pos_s1 == BYTE_POS_CRC);

	// stage 1 only waits when it holds a last byte and the output is held
	assign advance_s1 = !valid_s1 || !last_s1 || !out_valid_q || !out_stall;
	assign fire_s1    = valid_s1 && advance_s1;
	assign in_stall   = !advance_s1;

	assign crc_ok_s1  = (crc_next_s1 == 8'h00);
	assign present_s1 = crc_ok_s1 && (family_q == FAMILY_KEY);

	// priority match: lowest enabled slot wins
	always_comb begin
		hit_s1      = 1'b0;
		hit_slot_s1 = '0;
		for (int i = NUM_KEY_SLOTS - 1; i >= 0; i--) begin
			if (slot_en_q[i] && (key_slot_q[i] == serial_q)) begin
				hit_s1      = 1'b1;
				hit_slot_s1 = SLOT_IDX_W'(i);
			end
		end
	end

	always_comb begin
		result_s1.serial_number = serial_q;
		result_s1.family_code   = family_q;
		result_s1.crc_ok        = crc_ok_s1;
		result_s1.key_present   = present_s1;
		result_s1.key_allowed   = present_s1 && hit_s1;
		result_s1.matched_slot  = (present_s1 && hit_s1) ? hit_slot_s1 : '0;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
				key_slot_q[i] <= '0;
			end
			slot_en_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
				if (cfg_index == KEY_SLOT_REG[i]) begin
					key_slot_q[i] <= cfg_data;
				end
			end
			if (cfg_index == REG_SLOT_ENABLE) begin
				slot_en_q <= cfg_data[NUM_KEY_SLOTS-1:0];
			end
		end
	end

	// frame state: advance on every byte leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			byte_cnt_q <= '0;
			family_q   <= '0;
			serial_q   <= '0;
		end else if (fire_s1) begin
			byte_cnt_q <= pos_s1 + 3'd1;
			crc_q      <= last_s1 ? 8'h00 : crc_next_s1;
			if (pos_s1 == BYTE_POS_FAMILY) begin
				family_q <= item_s1.rom_byte;
			end
			for (int b = 0; b < SERIAL_BYTES; b++) begin
				if (pos_s1 == BYTE_POS_SERIAL0 + 3'(b)) begin
					serial_q[b*8 +: 8] <= item_s1.rom_byte;
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// output register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_item_q <= result_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`OWKC_ASSERT(a_out_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(fire_s1 && last_s1), "result appeared without a last byte")
	`OWKC_ASSERT(a_frame_wrap, clk, arst_n, (fire_s1 && last_s1) |=> (byte_cnt_q == BYTE_POS_FAMILY && crc_q == 8'h00), "frame did not restart after last byte")
	`OWKC_ASSERT_IMP(a_allowed_present, clk, arst_n, out_valid_q && out_item_q.key_allowed, out_item_q.key_present && out_item_q.crc_ok, "key allowed without valid key")
	`OWKC_ASSERT_IMP(a_slot_needs_hit, clk, arst_n, out_valid_q && (out_item_q.matched_slot != '0), out_item_q.key_allowed, "slot reported without match")
	`OWKC_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !(fire_s1 && last_s1), "held result overwritten")

endmodule

// ===== sim/tb_onewire_rom_key_check_unit.sv =====
module tb_onewire_rom_key_check_unit;
	import owkc_pkg::*;

	// Slots that take part in matching, same as the unit's default
	localparam int NUM_SLOTS        = MAX_KEY_SLOTS;
	// Indexes past the register list; writes there must change nothing
	localparam reg_idx_t REG_SPARE_SIX   = 3'd6;
	localparam reg_idx_t REG_SPARE_SEVEN = 3'd7;
	// Cycles to let the two-stage pipeline settle before touching registers
	localparam int SETTLE_CYCLES    = 4;
	// Length of the forced receiver hold-off, in clock cycles
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int PHASE_BYTES      = 580;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	reg_idx_t            cfg_index = '0;
	logic [SERIAL_W-1:0] cfg_data  = '0;

	// Bytes waiting to be offered, and key reports waiting to be seen
	in_item_t  rom_bytes_q[$];
	out_item_t key_reports_q[$];

	// Shadow of the unit: frame progress plus its register file
	logic [7:0]          crc_acc     = '0;
	logic [2:0]          byte_pos    = '0;
	logic [7:0]          fam_seen    = '0;
	logic [SERIAL_W-1:0] serial_seen = '0;
	logic [SERIAL_W-1:0] slot_model [NUM_SLOTS];
	logic [4:0]          enable_model = '0;

	int  err_count     = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_asks     = 0;
	int  hold_served   = 0;
	int  hold_left     = 0;
	bit  byte_taken    = 1'b0;

	onewire_rom_key_check_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the unit hangs or drops a transaction for good
	initial begin
		#2_000_000;
		$display("** onewire_rom_key_check_unit: FAILED **");
		$finish;
	end

	// Reflected 1-Wire CRC-8, fed one data bit at a time, LSB first
	function automatic logic [7:0] crc8_lsb_first(input logic [7:0] acc,
			input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ data[i];
			r  = r >> 1;
			if (fb)
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic [SERIAL_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[SERIAL_W-1:0];
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Advance the shadow by one accepted byte; queue a key report on the CRC byte
	task automatic predict_byte(input in_item_t it);
		out_item_t  rpt;
		logic [2:0] pos;
		if (it.frame_start) begin
			byte_pos = '0;
			crc_acc  = '0;
		end
		crc_acc = crc8_lsb_first(crc_acc, it.rom_byte);
		pos     = byte_pos;
		if (pos == BYTE_POS_FAMILY)
			fam_seen = it.rom_byte;
		else if (pos != BYTE_POS_CRC)
			serial_seen[(int'(pos) - 1) * 8 +: 8] = it.rom_byte;
		byte_pos = pos + 3'd1;
		if (pos == BYTE_POS_CRC) begin
			rpt               = '0;
			rpt.serial_number = serial_seen;
			rpt.family_code   = fam_seen;
			rpt.crc_ok        = (crc_acc == 8'h00);
			rpt.key_present   = rpt.crc_ok && (fam_seen == FAMILY_KEY);
			// lowest enabled slot wins
			if (rpt.key_present) begin
				for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
					if (enable_model[j] && slot_model[j] == serial_seen) begin
						rpt.key_allowed  = 1'b1;
						rpt.matched_slot = j[SLOT_IDX_W-1:0];
					end
				end
			end
			key_reports_q.push_back(rpt);
			crc_acc = '0;
		end
	endtask

	task automatic check_report(input out_item_t got);
		out_item_t want;
		if (key_reports_q.size() == 0) begin
			flag_error($sformatf("key report with none pending, serial %h family %h",
				got.serial_number, got.family_code));
			return;
		end
		want = key_reports_q.pop_front();
		if (got.serial_number !== want.serial_number)
			flag_error($sformatf("serial_number %h, want %h",
				got.serial_number, want.serial_number));
		if (got.family_code !== want.family_code)
			flag_error($sformatf("family_code %h, want %h",
				got.family_code, want.family_code));
		if (got.crc_ok !== want.crc_ok)
			flag_error($sformatf("crc_ok %b, want %b", got.crc_ok, want.crc_ok));
		if (got.key_present !== want.key_present)
			flag_error($sformatf("key_present %b, want %b",
				got.key_present, want.key_present));
		if (got.key_allowed !== want.key_allowed)
			flag_error($sformatf("key_allowed %b, want %b",
				got.key_allowed, want.key_allowed));
		if (got.matched_slot !== want.matched_slot)
			flag_error($sformatf("matched_slot %0d, want %0d",
				got.matched_slot, want.matched_slot));
	endtask

	// Sample both channels at the rising edge: predict on accepted bytes,
	// check every accepted result transaction against the oldest prediction.
	always @(posedge clk) begin
		byte_taken = in_valid && !in_stall;
		if (arst_n) begin
			if (byte_taken)
				predict_byte(in_item);
			if (out_valid && !out_stall)
				check_report(out_item);
		end
	end

	// Byte driver: advance only after the current transaction was taken,
	// otherwise hold valid and payload steady.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_taken) begin
			if (rom_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_item  <= rom_bytes_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off on request so the
	// unit backs up and stalls its byte input.
	always @(negedge clk) begin
		if (hold_served != hold_asks) begin
			hold_served = hold_asks;
			hold_left   = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Register write transaction; mirror it into the shadow once it lands
	task automatic write_reg(input reg_idx_t idx, input logic [SERIAL_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= REG_KEY_SLOT_FOUR)
			slot_model[idx] = data;
		else if (idx == REG_SLOT_ENABLE)
			enable_model = data[4:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Load random slots (some copied from the previous one so the lowest-match
	// rule gets exercised), the enable mask with junk above bit 4, and one
	// write past the register list.
	task automatic program_slots(input logic [4:0] mask);
		logic [SERIAL_W-1:0] v;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			v = rand48();
			if (j > 0 && $urandom_range(3) == 0)
				v = slot_model[j-1];
			write_reg(KEY_SLOT_REG[j], v);
		end
		v = rand48();
		write_reg(REG_SLOT_ENABLE, {v[SERIAL_W-1:5], mask});
		write_reg($urandom_range(1) ? REG_SPARE_SIX : REG_SPARE_SEVEN, rand48());
	endtask

	// Queue one ROM frame; a nonzero crc_flip corrupts the CRC byte
	task automatic queue_frame(input logic [7:0] fam, input logic [SERIAL_W-1:0] ser,
			input logic [7:0] crc_flip, input logic mark);
		logic [7:0] crc;
		in_item_t   it;
		crc             = crc8_lsb_first(8'h00, fam);
		it.rom_byte     = fam;
		it.frame_start  = mark;
		rom_bytes_q.push_back(it);
		it.frame_start  = 1'b0;
		for (int k = 0; k < SERIAL_BYTES; k++) begin
			it.rom_byte = ser[k*8 +: 8];
			crc         = crc8_lsb_first(crc, it.rom_byte);
			rom_bytes_q.push_back(it);
		end
		it.rom_byte = crc ^ crc_flip;
		rom_bytes_q.push_back(it);
	endtask

	// Mostly well-formed frames aimed at the slots; the rest is loose bytes
	// with stray start marks that knock the frame alignment around.
	task automatic queue_traffic(input int n_bytes);
		int                  target;
		logic [7:0]          fam;
		logic [SERIAL_W-1:0] ser;
		in_item_t            it;
		target = rom_bytes_q.size() + n_bytes;
		while (rom_bytes_q.size() < target) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 7)) begin
					it.rom_byte    = 8'($urandom_range(255));
					it.frame_start = ($urandom_range(4) == 0);
					rom_bytes_q.push_back(it);
				end
			end else begin
				fam = ($urandom_range(4) != 0) ? FAMILY_KEY : 8'($urandom_range(255));
				case ($urandom_range(3))
					0, 1: ser = slot_model[$urandom_range(NUM_SLOTS - 1)];
					2: ser = slot_model[$urandom_range(NUM_SLOTS - 1)]
						^ (48'h1 << $urandom_range(SERIAL_W - 1));
					default: ser = rand48();
				endcase
				queue_frame(fam, ser,
					($urandom_range(7) != 0) ? 8'h00 : 8'($urandom_range(1, 255)),
					($urandom_range(9) < 7));
			end
		end
	endtask

	// Wait until every byte is out and every report came back, then settle
	task automatic drain();
		while (rom_bytes_q.size() != 0 || in_valid || key_reports_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		in_item_t it;
		for (int j = 0; j < NUM_SLOTS; j++)
			slot_model[j] = '0;

		// Hold reset, then release it on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed register setup: slot extremes, a duplicated slot, full mask
		// written with every data bit high, and both spare indexes.
		write_reg(REG_KEY_SLOT_ZERO, '0);
		write_reg(REG_KEY_SLOT_ONE, '1);
		write_reg(REG_KEY_SLOT_TWO, rand48());
		write_reg(REG_KEY_SLOT_THREE, slot_model[2]);
		write_reg(REG_KEY_SLOT_FOUR, rand48());
		write_reg(REG_SLOT_ENABLE, '1);
		write_reg(REG_SPARE_SIX, '0);
		write_reg(REG_SPARE_SEVEN, '1);
		@(posedge clk);

		// Good key matching two slots: lowest one must be reported
		queue_frame(FAMILY_KEY, slot_model[2], 8'h00, 1'b1);
		// Two bytes of a frame, then a start mark in mid frame
		it.rom_byte    = 8'h01;
		it.frame_start = 1'b1;
		rom_bytes_q.push_back(it);
		it.rom_byte    = 8'hFF;
		it.frame_start = 1'b0;
		rom_bytes_q.push_back(it);
		queue_frame(FAMILY_KEY, '1, 8'h00, 1'b1);
		// Back-to-back frame without start mark: good CRC, wrong family
		queue_frame(8'hFF, '0, 8'h00, 1'b0);
		drain();

		// Three random phases: receiver-heavy idling, sender-heavy idling, none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: program_slots(5'($urandom_range(1, 31)));
				1: program_slots(5'h00);
				default: program_slots(5'h1F);
			endcase
			@(posedge clk);
			send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 34 : 0;
			if (phase != 0)
				hold_asks++;
			if (phase == 0) begin
				// Pause the sender midway until every report is back
				queue_traffic(PHASE_BYTES / 2);
				drain();
				queue_traffic(PHASE_BYTES / 2);
			end else begin
				queue_traffic(PHASE_BYTES);
			end
			drain();
		end

		if (key_reports_q.size() != 0)
			flag_error($sformatf("%0d key reports never arrived", key_reports_q.size()));
		if (err_count == 0)
			$display("** onewire_rom_key_check_unit: PASSED **");
		else
			$display("** onewire_rom_key_check_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/owkc_pkg.sv
src/onewire_rom_key_check_unit.sv
sim/tb_onewire_rom_key_check_unit.sv
